[src/lts_pkg.sv]
`default_nettype none

package lts_pkg;

  // One token as it leaves the scanner (the last flag is added at the output)
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start_res;
    logic [15:0] length;
    logic [15:0] line;
  } lts_tok_t;

  // Most tokens one character can cause: number, dot, then one more
  localparam int unsigned MAX_TOKS = 3;

  // All tokens caused by one request, oldest in slot 0
  typedef struct packed {
    logic [1:0]                  cnt;
    lts_tok_t [MAX_TOKS-1:0]     tok;
  } lts_group_t;

  // Result queue depth in groups
  localparam int unsigned QDEPTH = 4;

  // Token kind codes
  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COMMA   = 6'd4;
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_MINUS   = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd7;
  localparam logic [5:0] K_SEMI    = 6'd8;
  localparam logic [5:0] K_SLASH   = 6'd9;
  localparam logic [5:0] K_STAR    = 6'd10;
  localparam logic [5:0] K_BANG    = 6'd11;
  localparam logic [5:0] K_BANG_EQ = 6'd12;
  localparam logic [5:0] K_EQ      = 6'd13;
  localparam logic [5:0] K_EQ_EQ   = 6'd14;
  localparam logic [5:0] K_GT      = 6'd15;
  localparam logic [5:0] K_GT_EQ   = 6'd16;
  localparam logic [5:0] K_LT      = 6'd17;
  localparam logic [5:0] K_LT_EQ   = 6'd18;
  localparam logic [5:0] K_IDENT   = 6'd19;
  localparam logic [5:0] K_STRING  = 6'd20;
  localparam logic [5:0] K_NUMBER  = 6'd21;
  localparam logic [5:0] K_KW_BASE = 6'd22;
  localparam logic [5:0] K_END     = 6'd38;
  localparam logic [5:0] K_BADCHAR = 6'd39;
  localparam logic [5:0] K_OPENSTR = 6'd40;

  // Keywords, packed first character highest, with their lengths
  localparam int unsigned NUM_KW = 16;
  localparam logic [47:0] KW_TEXT [NUM_KW] = '{
    48'h000000616e64, // and
    48'h00636c617373, // class
    48'h0000656c7365, // else
    48'h0066616c7365, // false
    48'h00000066756e, // fun
    48'h000000666f72, // for
    48'h000000006966, // if
    48'h0000006e696c, // nil
    48'h000000006f72, // or
    48'h007072696e74, // print
    48'h72657475726e, // return
    48'h007375706572, // super
    48'h000074686973, // this
    48'h000074727565, // true
    48'h000000766172, // var
    48'h007768696c65  // while
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
    3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
  };

  // Kind of a finished word: a keyword if prefix and length match one
  function automatic logic [5:0] word_kind(input logic [47:0] pref, input logic [2:0] len);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if (len == KW_LEN[i] && pref == KW_TEXT[i]) begin
        k = K_KW_BASE + 6'(i);
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

[src/lts_ifs.sv]
`default_nettype none

// Character request channel
interface lts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;

  modport source (output valid, output ch, output end_of_source, input ready);
  modport sink   (input valid, input ch, input end_of_source, output ready);
endinterface

// Token result channel
interface lts_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  kind;
  logic [15:0] start_res;
  logic [15:0] length;
  logic [15:0] line;
  logic        last;

  modport source (output valid, output kind, output start_res, output length,
                  output line, output last, input ready);
  modport sink   (input valid, input kind, input start_res, input length,
                  input line, input last, output ready);
endinterface

`default_nettype wire

[src/lts_scan.sv]
`default_nettype none

module lts_scan #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_take,
  input  wire logic [7:0]         in_ch,
  input  wire logic               in_eos,
  output logic                    push_valid,
  output lts_pkg::lts_group_t     push_group
);
  import lts_pkg::*;

  // Scan modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_BANG    = 4'd1;
  localparam logic [3:0] M_EQ      = 4'd2;
  localparam logic [3:0] M_LT      = 4'd3;
  localparam logic [3:0] M_GT      = 4'd4;
  localparam logic [3:0] M_SLASH   = 4'd5;
  localparam logic [3:0] M_COMMENT = 4'd6;
  localparam logic [3:0] M_STRING  = 4'd7;
  localparam logic [3:0] M_INT     = 4'd8;
  localparam logic [3:0] M_DOT     = 4'd9;
  localparam logic [3:0] M_FRAC    = 4'd10;
  localparam logic [3:0] M_WORD    = 4'd11;

  // Blank characters without a printable form
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  // Input stage
  logic                     valid_r;
  logic [7:0]               ch_r;
  logic                     eos_r;

  // Scan state
  logic [3:0]               mode_r,  mode_nxt;
  logic [POSITION_BITS-1:0] ts_r,    ts_nxt;
  logic [POSITION_BITS-1:0] pos_r,   pos_nxt;
  logic [15:0]              line_r,  line_nxt;
  logic [47:0]              pref_r,  pref_nxt;
  logic [2:0]               wlen_r,  wlen_nxt;

  logic [POSITION_BITS+15:0] pos_ext, ts_ext;
  logic [15:0]              p16, ts16;
  logic                     is_dig, is_alpha;
  logic                     taken, fin, beg;
  logic [1:0]               n;
  lts_tok_t [MAX_TOKS-1:0]  toks;

  function automatic lts_tok_t mk(input logic [5:0] k, input logic [15:0] s,
                                  input logic [15:0] l, input logic [15:0] ln);
    lts_tok_t t;
    t.kind      = k;
    t.start_res = s;
    t.length    = l;
    t.line      = ln;
    return t;
  endfunction

  // Low 16 bits of position and token start, whatever the position width
  assign pos_ext = {16'd0, pos_r};
  assign ts_ext  = {16'd0, ts_r};
  assign p16     = pos_ext[15:0];
  assign ts16    = ts_ext[15:0];

  assign is_dig   = (ch_r >= "0") && (ch_r <= "9");
  assign is_alpha = ((ch_r >= "a") && (ch_r <= "z")) || ((ch_r >= "A") && (ch_r <= "Z"))
                    || (ch_r == "_");

  // Next state and tokens for the staged character
  always_comb begin
    mode_nxt = mode_r;
    ts_nxt   = ts_r;
    pos_nxt  = pos_r;
    line_nxt = line_r;
    pref_nxt = pref_r;
    wlen_nxt = wlen_r;
    toks     = '0;
    n        = 2'd0;
    taken    = 1'b0;
    fin      = 1'b0;
    beg      = 1'b0;

    if (valid_r) begin
      if (eos_r) begin
        fin = 1'b1;
      end else begin
        // continue the pending token if this character belongs to it
        unique case (mode_r) inside
          M_BANG, M_EQ, M_LT, M_GT: begin
            if (ch_r == "=") begin
              taken = 1'b1;
              mode_nxt = M_IDLE;
              toks[n] = mk((mode_r == M_BANG) ? K_BANG_EQ :
                           (mode_r == M_EQ)   ? K_EQ_EQ   :
                           (mode_r == M_LT)   ? K_LT_EQ   : K_GT_EQ,
                           ts16, p16 + 16'd1 - ts16, line_r);
              n = n + 2'd1;
            end
          end
          M_SLASH: begin
            if (ch_r == "/") begin
              taken = 1'b1;
              mode_nxt = M_COMMENT;
            end
          end
          M_COMMENT: taken = (ch_r != CH_NL);
          M_STRING: begin
            taken = 1'b1;
            if (ch_r == "\"") begin
              mode_nxt = M_IDLE;
              toks[n] = mk(K_STRING, ts16, p16 + 16'd1 - ts16, line_r);
              n = n + 2'd1;
            end else if (ch_r == CH_NL && line_r != 16'hffff) begin
              line_nxt = line_r + 16'd1;
            end
          end
          M_INT: begin
            if (is_dig) begin
              taken = 1'b1;
            end else if (ch_r == ".") begin
              taken = 1'b1;
              mode_nxt = M_DOT;
            end
          end
          M_DOT: begin
            if (is_dig) begin
              taken = 1'b1;
              mode_nxt = M_FRAC;
            end
          end
          M_FRAC: taken = is_dig;
          M_WORD: begin
            if (is_alpha || is_dig) begin
              taken = 1'b1;
              if (wlen_r < 3'd6) begin
                pref_nxt = {pref_r[39:0], ch_r};
                wlen_nxt = wlen_r + 3'd1;
              end else begin
                wlen_nxt = 3'd7;
              end
            end
          end
          default: ;
        endcase
        fin = !taken;
        beg = !taken;
        pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + POSITION_BITS'(1);
      end

      // close the pending token just before the current position
      if (fin) begin
        unique case (mode_r) inside
          M_BANG:  begin toks[n] = mk(K_BANG,  ts16, 16'd1, line_r); n = n + 2'd1; end
          M_EQ:    begin toks[n] = mk(K_EQ,    ts16, 16'd1, line_r); n = n + 2'd1; end
          M_LT:    begin toks[n] = mk(K_LT,    ts16, 16'd1, line_r); n = n + 2'd1; end
          M_GT:    begin toks[n] = mk(K_GT,    ts16, 16'd1, line_r); n = n + 2'd1; end
          M_SLASH: begin toks[n] = mk(K_SLASH, ts16, 16'd1, line_r); n = n + 2'd1; end
          M_STRING: begin
            toks[n] = mk(K_OPENSTR, ts16, p16 - ts16, line_r);
            n = n + 2'd1;
          end
          M_INT, M_FRAC: begin
            toks[n] = mk(K_NUMBER, ts16, p16 - ts16, line_r);
            n = n + 2'd1;
          end
          M_DOT: begin
            // number without the held-back dot, then the dot itself
            toks[n] = mk(K_NUMBER, ts16, p16 - 16'd1 - ts16, line_r);
            n = n + 2'd1;
            toks[n] = mk(K_DOT, p16 - 16'd1, 16'd1, line_r);
            n = n + 2'd1;
          end
          M_WORD: begin
            toks[n] = mk(word_kind(pref_r, wlen_r), ts16, p16 - ts16, line_r);
            n = n + 2'd1;
          end
          default: ;
        endcase
        mode_nxt = M_IDLE;
      end

      if (eos_r) begin
        toks[n] = mk(K_END, p16, 16'd0, line_r);
        n = n + 2'd1;
      end

      // start a new token from idle
      if (beg) begin
        ts_nxt = pos_r;
        case (ch_r) inside
          "(": begin toks[n] = mk(K_LPAREN, p16, 16'd1, line_r); n = n + 2'd1; end
          ")": begin toks[n] = mk(K_RPAREN, p16, 16'd1, line_r); n = n + 2'd1; end
          "{": begin toks[n] = mk(K_LBRACE, p16, 16'd1, line_r); n = n + 2'd1; end
          "}": begin toks[n] = mk(K_RBRACE, p16, 16'd1, line_r); n = n + 2'd1; end
          ",": begin toks[n] = mk(K_COMMA,  p16, 16'd1, line_r); n = n + 2'd1; end
          ".": begin toks[n] = mk(K_DOT,    p16, 16'd1, line_r); n = n + 2'd1; end
          "-": begin toks[n] = mk(K_MINUS,  p16, 16'd1, line_r); n = n + 2'd1; end
          "+": begin toks[n] = mk(K_PLUS,   p16, 16'd1, line_r); n = n + 2'd1; end
          ";": begin toks[n] = mk(K_SEMI,   p16, 16'd1, line_r); n = n + 2'd1; end
          "*": begin toks[n] = mk(K_STAR,   p16, 16'd1, line_r); n = n + 2'd1; end
          "!": mode_nxt = M_BANG;
          "=": mode_nxt = M_EQ;
          "<": mode_nxt = M_LT;
          ">": mode_nxt = M_GT;
          "/": mode_nxt = M_SLASH;
          " ", CH_CR, CH_TAB: ;
          CH_NL: begin
            if (line_r != 16'hffff) line_nxt = line_r + 16'd1;
          end
          "\"": mode_nxt = M_STRING;
          default: begin
            if (is_dig) begin
              mode_nxt = M_INT;
            end else if (is_alpha) begin
              mode_nxt = M_WORD;
              pref_nxt = {40'd0, ch_r};
              wlen_nxt = 3'd1;
            end else begin
              toks[n] = mk(K_BADCHAR, p16, 16'd1, line_r);
              n = n + 2'd1;
            end
          end
        endcase
      end
    end
  end

  assign push_valid     = (n != 2'd0);
  assign push_group.cnt = n;
  assign push_group.tok = toks;

  // Input stage payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      ch_r  <= in_ch;
      eos_r <= in_eos;
    end
  end

  // Control and scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mode_r  <= M_IDLE;
      ts_r    <= '0;
      pos_r   <= '0;
      line_r  <= 16'd1;
      pref_r  <= '0;
      wlen_r  <= '0;
    end else begin
      valid_r <= in_take;
      mode_r  <= mode_nxt;
      ts_r    <= ts_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
      pref_r  <= pref_nxt;
      wlen_r  <= wlen_nxt;
    end
  end

endmodule

`default_nettype wire

[src/lts_resq.sv]
`default_nettype none

module lts_resq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  input  wire lts_pkg::lts_group_t push_group,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lts_pkg::lts_tok_t       out_tok,
  output logic                    out_last
);
  import lts_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(QDEPTH - 2);

  lts_group_t         grp_r [QDEPTH];
  logic [PW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [1:0]         sub_r;
  lts_group_t         head;
  logic               pop_tok, pop_grp;

  assign head      = grp_r[rd_ptr_r];
  assign out_valid = (count_r != '0);
  assign out_tok   = head.tok[sub_r];
  assign out_last  = (sub_r == head.cnt - 2'd1);
  assign pop_tok   = out_valid && out_ready;
  assign pop_grp   = pop_tok && out_last;

  // room for the staged request plus one newly accepted
  assign room = (count_r <= ROOM_MAX);

  always_comb begin
    count_nxt = count_r;
    if (push_valid && !pop_grp) count_nxt = count_r + CW'(1);
    else if (!push_valid && pop_grp) count_nxt = count_r - CW'(1);
  end

  // Group storage
  always_ff @(posedge clk) begin
    if (push_valid) grp_r[wr_ptr_r] <= push_group;
  end

  // Pointers and token index within the head group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      sub_r    <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_valid) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop_grp) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
        sub_r    <= '0;
      end else if (pop_tok) begin
        sub_r <= sub_r + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[src/lexical_token_scanner.sv]
`default_nettype none

// Channel   Dir  Payload                                   Transfer
// in_req    in   ch[7:0], end_of_source                    valid & ready
// out_res   out  kind[5:0], start_res, length, line, last  valid & ready
//
// One character per cycle: a request is staged, scanned in one pass and its
// tokens (up to three) go as one group into a four-group result queue.
// Tokens leave one per cycle; ready drops once fewer than two groups are free,
// so multi-token requests or a stalled receiver slow the input.
// A token reaches out_res once its request has passed the input stage and been written into the result queue.
// Reset (synchronous, rst_n low) clears the scan state and empties the queue.
module lexical_token_scanner #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lts_in_if.sink     in_req,
  lts_out_if.source  out_res
);
  import lts_pkg::*;

  logic       take;
  logic       room;
  logic       push_valid;
  lts_group_t push_group;
  lts_tok_t   tok;

  assign in_req.ready = room;
  assign take         = in_req.valid && room;

  lts_scan #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (take),
    .in_ch      (in_req.ch),
    .in_eos     (in_req.end_of_source),
    .push_valid (push_valid),
    .push_group (push_group)
  );

  lts_resq u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_group (push_group),
    .room       (room),
    .out_valid  (out_res.valid),
    .out_ready  (out_res.ready),
    .out_tok    (tok),
    .out_last   (out_res.last)
  );

  assign out_res.kind      = tok.kind;
  assign out_res.start_res = tok.start_res;
  assign out_res.length    = tok.length;
  assign out_res.line      = tok.line;

endmodule

`default_nettype wire

[tb/lexical_token_scanner_tb.sv]
`timescale 1ns / 1ps

module lexical_token_scanner_tb;
  import lts_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int OP_COUNT       = 19;

  // Scanner modes of the predictor
  typedef enum logic [3:0] {
    SC_IDLE, SC_BANG, SC_EQ, SC_LT, SC_GT, SC_SLASH, SC_COMMENT,
    SC_STRING, SC_INT, SC_DOT, SC_FRAC, SC_WORD
  } scan_mode_e;

  // One expected token with its end-of-request flag
  typedef struct packed {
    lts_tok_t tok;
    logic     last;
  } token_res_t;

  logic clk;
  logic rst_n;

  lts_in_if  in_ch ();
  lts_out_if out_ch ();

  lexical_token_scanner dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_res (out_ch)
  );

  string kw_names [16] = '{
    "and", "class", "else", "false", "fun", "for", "if", "nil",
    "or", "print", "return", "super", "this", "true", "var", "while"
  };
  string op_texts [OP_COUNT] = '{
    "(", ")", "{", "}", ",", ".", "-", "+", ";", "*",
    "!", "!=", "=", "==", "<", "<=", ">", ">=", "/"
  };

  // Predictor state, reset values
  scan_mode_e  lex_mode  = SC_IDLE;
  logic [15:0] tok_start = 16'd0;
  logic [15:0] cur_pos   = 16'd0;
  logic [15:0] cur_line  = 16'd1;
  logic [47:0] word_text = 48'd0;
  logic [2:0]  word_len  = 3'd0;

  token_res_t pending_tokens [$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_req;
  int hold_left;
  int sent_items;
  int tokens_checked;
  int mismatches;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic void bump_line();
    if (cur_line != 16'hFFFF) cur_line = cur_line + 16'd1;
  endfunction

  function automatic void add_tok(input logic [5:0] kind, input logic [15:0] start,
                                  input logic [15:0] len);
    token_res_t t;
    t.tok.kind      = kind;
    t.tok.start_res = start;
    t.tok.length    = len;
    t.tok.line      = cur_line;
    t.last          = 1'b0;
    pending_tokens.insert(pending_tokens.size(), t);
  endfunction

  // Keyword or plain identifier, from the captured prefix and length
  function automatic logic [5:0] keyword_kind();
    logic [47:0] v;
    logic [5:0]  k;
    k = K_IDENT;
    for (int i = 0; i < 16; i++) begin
      v = 48'd0;
      for (int j = 0; j < kw_names[i].len(); j++) v = {v[39:0], kw_names[i][j]};
      if (word_len == 3'(kw_names[i].len()) && v == word_text) k = K_KW_BASE + 6'(i);
    end
    return k;
  endfunction

  // Emit whatever token is open, as ending just before p
  function automatic void close_token(input logic [15:0] p);
    case (lex_mode)
      SC_BANG:   add_tok(K_BANG, tok_start, 16'd1);
      SC_EQ:     add_tok(K_EQ, tok_start, 16'd1);
      SC_LT:     add_tok(K_LT, tok_start, 16'd1);
      SC_GT:     add_tok(K_GT, tok_start, 16'd1);
      SC_SLASH:  add_tok(K_SLASH, tok_start, 16'd1);
      SC_STRING: add_tok(K_OPENSTR, tok_start, p - tok_start);
      SC_INT, SC_FRAC: add_tok(K_NUMBER, tok_start, p - tok_start);
      SC_DOT: begin
        add_tok(K_NUMBER, tok_start, p - 16'd1 - tok_start);
        add_tok(K_DOT, p - 16'd1, 16'd1);
      end
      SC_WORD:   add_tok(keyword_kind(), tok_start, p - tok_start);
      default: ;
    endcase
    lex_mode = SC_IDLE;
  endfunction

  // Advance the predictor by one request and queue the tokens it causes
  function automatic void scan_char(input logic [7:0] c, input logic eos);
    logic [15:0] p;
    bit taken;
    int before_cnt;
    p = cur_pos;
    taken = 1'b0;
    before_cnt = pending_tokens.size();
    if (eos) begin
      close_token(p);
      add_tok(K_END, p, 16'd0);
    end else begin
      case (lex_mode)
        SC_BANG, SC_EQ, SC_LT, SC_GT: begin
          if (c == "=") begin
            add_tok(lex_mode == SC_BANG ? K_BANG_EQ : lex_mode == SC_EQ ? K_EQ_EQ :
                    lex_mode == SC_LT ? K_LT_EQ : K_GT_EQ,
                    tok_start, p + 16'd1 - tok_start);
            lex_mode = SC_IDLE;
            taken = 1'b1;
          end
        end
        SC_SLASH: begin
          if (c == "/") begin
            lex_mode = SC_COMMENT;
            taken = 1'b1;
          end
        end
        SC_COMMENT: taken = (c != "\n");
        SC_STRING: begin
          taken = 1'b1;
          if (c == "\"") begin
            add_tok(K_STRING, tok_start, p + 16'd1 - tok_start);
            lex_mode = SC_IDLE;
          end else if (c == "\n") begin
            bump_line();
          end
        end
        SC_INT: begin
          if (is_digit(c)) begin
            taken = 1'b1;
          end else if (c == ".") begin
            lex_mode = SC_DOT;
            taken = 1'b1;
          end
        end
        SC_DOT: begin
          if (is_digit(c)) begin
            lex_mode = SC_FRAC;
            taken = 1'b1;
          end
        end
        SC_FRAC: taken = is_digit(c);
        SC_WORD: begin
          if (is_alpha(c) || is_digit(c)) begin
            taken = 1'b1;
            if (word_len < 3'd6) begin
              word_text = {word_text[39:0], c};
              word_len  = word_len + 3'd1;
            end else begin
              word_len = 3'd7;
            end
          end
        end
        default: ;
      endcase

      // Character not absorbed: close the open token and start a new one here
      if (!taken) begin
        close_token(p);
        tok_start = p;
        case (c)
          "(": add_tok(K_LPAREN, p, 16'd1);
          ")": add_tok(K_RPAREN, p, 16'd1);
          "{": add_tok(K_LBRACE, p, 16'd1);
          "}": add_tok(K_RBRACE, p, 16'd1);
          ",": add_tok(K_COMMA, p, 16'd1);
          ".": add_tok(K_DOT, p, 16'd1);
          "-": add_tok(K_MINUS, p, 16'd1);
          "+": add_tok(K_PLUS, p, 16'd1);
          ";": add_tok(K_SEMI, p, 16'd1);
          "*": add_tok(K_STAR, p, 16'd1);
          "!": lex_mode = SC_BANG;
          "=": lex_mode = SC_EQ;
          "<": lex_mode = SC_LT;
          ">": lex_mode = SC_GT;
          "/": lex_mode = SC_SLASH;
          " ", "\r", "\t": ;
          "\n": bump_line();
          "\"": lex_mode = SC_STRING;
          default: begin
            if (is_digit(c)) begin
              lex_mode = SC_INT;
            end else if (is_alpha(c)) begin
              lex_mode  = SC_WORD;
              word_text = {40'd0, c};
              word_len  = 3'd1;
            end else begin
              add_tok(K_BADCHAR, p, 16'd1);
            end
          end
        endcase
      end
      if (cur_pos != 16'hFFFF) cur_pos = cur_pos + 16'd1;
    end
    if (pending_tokens.size() > before_cnt)
      pending_tokens[pending_tokens.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.ch            <= c;
    in_ch.end_of_source <= eos;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
    scan_char(c, eos);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_req(s[i], 1'b0);
  endtask

  // Sender pauses until every expected token has come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_word_char(input bit first);
    int r;
    r = $urandom_range(first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  // One random lexeme, mostly well formed, some noise and end markers
  task automatic send_random_lexeme();
    int n;
    logic [7:0] c;
    case ($urandom_range(11))
      0, 1: begin
        send_text(kw_names[$urandom_range(15)]);
        if ($urandom_range(3) == 0) send_req(rand_word_char(1'b0), 1'b0);
        if ($urandom_range(1) == 0) send_req(" ", 1'b0);
      end
      2: begin
        n = $urandom_range(8);
        send_req(rand_word_char(1'b1), 1'b0);
        repeat (n) send_req(rand_word_char(1'b0), 1'b0);
      end
      3, 4: begin
        n = $urandom_range(2);
        repeat (n + 1) send_req(rand_digit(), 1'b0);
        case ($urandom_range(3))
          1: begin
            send_req(".", 1'b0);
            repeat (n + 1) send_req(rand_digit(), 1'b0);
          end
          2: send_req(".", 1'b0);
          default: ;
        endcase
      end
      5: begin
        send_req("\"", 1'b0);
        repeat ($urandom_range(6)) begin
          c = ($urandom_range(7) == 0) ? "\n" : 8'($urandom_range(32, 126));
          if (c == "\"") c = "'";
          send_req(c, 1'b0);
        end
        if ($urandom_range(5) != 0) send_req("\"", 1'b0);
      end
      6, 7: send_text(op_texts[$urandom_range(OP_COUNT - 1)]);
      8: begin
        send_text("//");
        repeat ($urandom_range(5)) send_req(8'($urandom_range(32, 126)), 1'b0);
        send_req("\n", 1'b0);
      end
      9: begin
        case ($urandom_range(3))
          0: c = " ";
          1: c = "\t";
          2: c = "\r";
          default: c = "\n";
        endcase
        send_req(c, 1'b0);
      end
      10: send_req(8'($urandom_range(255)), 1'b0);
      default: send_req(8'($urandom_range(255)), 1'b1);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_operators();
    send_text("(){},.-+;* ! != = == < <= > >= /;");
  endtask

  // Number then dot, comment, newline inside a string, END
  task automatic test_special_cases();
    send_text("1.5 2.x 3..4//c\n\"a\nb\"");
    send_req(8'h00, 1'b1);
  endtask

  // NUL and high bytes, open string at end, scanning after END
  task automatic test_odd_bytes();
    send_req(8'h00, 1'b0);
    send_req(8'hFF, 1'b0);
    send_text("@\"ab");
    send_req(8'hFF, 1'b1);
    send_text("x9");
    send_req(8'h7F, 1'b1);
  endtask

  task automatic test_random(input int count);
    int target;
    target = sent_items + count;
    while (sent_items < target) send_random_lexeme();
  endtask

  // Receiver holds off while three-token requests keep coming
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    repeat (6) send_text("1.(");
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: receiver pacing and checking
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < 40)
      $display("mismatch on token %0d: %s got %0d expected %0d",
               tokens_checked, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_tokens
    token_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch("unexpected token kind", 16'(out_ch.kind), 16'd0);
      end else begin
        want = pending_tokens.pop_front();
        if (out_ch.kind !== want.tok.kind)
          report_mismatch("kind", 16'(out_ch.kind), 16'(want.tok.kind));
        if (out_ch.start_res !== want.tok.start_res)
          report_mismatch("start", out_ch.start_res, want.tok.start_res);
        if (out_ch.length !== want.tok.length)
          report_mismatch("length", out_ch.length, want.tok.length);
        if (out_ch.line !== want.tok.line)
          report_mismatch("line", out_ch.line, want.tok.line);
        if (out_ch.last !== want.last)
          report_mismatch("last", 16'(out_ch.last), 16'(want.last));
      end
      tokens_checked++;
    end
  end

  // Watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("[lexical_token_scanner] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.ch            <= 8'h00;
    in_ch.end_of_source <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slow sender, slow receiver
    send_idle_pct = 30;
    recv_idle_pct = 75;
    test_operators();
    test_special_cases();
    test_odd_bytes();
    test_random(12);
    wait_idle();

    // Roles swapped
    send_idle_pct = 75;
    recv_idle_pct = 30;
    test_backpressure();
    test_random(12);
    wait_idle();

    // No idling at all
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(12);
    wait_idle();

    $display("sent %0d requests, checked %0d tokens, %0d mismatches",
             sent_items, tokens_checked, mismatches);
    $display("covered operators, literals, keywords, errors, END and a full result queue");
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("[lexical_token_scanner] OK");
    end else begin
      $display("[lexical_token_scanner] ERROR");
    end
    $finish;
  end

endmodule
